// ===== sv/ccs_pkg.sv =====
`timescale 1ns / 1ps

package ccs_pkg;

  localparam int unsigned FrameData = 7;
  localparam logic [7:0] CheckByte = 8'h6B;
  localparam logic [7:0] LastPacket = 8'hFF;
  localparam logic [3:0] FullLength = 4'd8;

  typedef struct packed {
    logic       last;
    logic       has;
    logic [7:0] data;
    logic [7:0] code;
    logic [7:0] addr;
  } in_word_t;

  typedef struct packed {
    logic            ovf;
    logic            fin;
    logic [7:0][7:0] data;
    logic [3:0]      len;
    logic [15:0]     id;
  } frame_t;

endpackage

// ===== sv/ccs_seg_core.sv =====
`timescale 1ns / 1ps

module ccs_seg_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  ccs_pkg::in_word_t in_i,
  output logic [1:0]      num_o,
  output ccs_pkg::frame_t frame0_o,
  output ccs_pkg::frame_t frame1_o
);
  import ccs_pkg::*;

  logic [7:0] pending_q [FrameData];
  logic [2:0] fill_q, fill_d, fill1;
  logic [7:0] pkt_q, pkt_d, pkt1;
  logic       disc_q, disc_d;
  logic       full;
  frame_t     full_f, tail_f;

  assign full  = in_i.has && (fill_q == 3'(FrameData - 1));
  assign pkt1  = full ? pkt_q + 8'd1 : pkt_q;
  assign fill1 = full ? 3'd0 : (in_i.has ? fill_q + 3'd1 : fill_q);

  always_comb begin
    full_f         = '0;
    full_f.id      = {in_i.addr, pkt_q};
    full_f.len     = FullLength;
    full_f.data[0] = in_i.code;
    for (int j = 0; j < FrameData - 1; j++) begin
      full_f.data[j + 1] = pending_q[j];
    end
    full_f.data[FrameData] = in_i.data;
    full_f.fin = (pkt_q == LastPacket);
    full_f.ovf = (pkt_q == LastPacket);

    tail_f         = '0;
    tail_f.id      = {in_i.addr, pkt1};
    tail_f.len     = 4'(fill1) + 4'd2;
    tail_f.data[0] = in_i.code;
    tail_f.fin     = 1'b1;
    for (int j = 0; j < FrameData; j++) begin
      if (3'(j) < fill1) begin
        tail_f.data[j + 1] = (in_i.has && !full && 3'(j) == fill_q) ? in_i.data
                                                                     : pending_q[j];
      end else if (3'(j) == fill1) begin
        tail_f.data[j + 1] = CheckByte;
      end
    end
  end

  always_comb begin
    fill_d   = fill_q;
    pkt_d    = pkt_q;
    disc_d   = disc_q;
    num_o    = 2'd0;
    frame0_o = full_f;
    frame1_o = tail_f;
    if (in_fire_i) begin
      if (disc_q) begin
        if (in_i.last) begin
          fill_d = '0;
          pkt_d  = '0;
          disc_d = 1'b0;
        end
      end else if (full && pkt_q == LastPacket) begin
        // packet space used up, drop the rest of the command
        num_o  = 2'd1;
        fill_d = '0;
        pkt_d  = '0;
        disc_d = !in_i.last;
      end else begin
        if (full) begin
          num_o = 2'd1;
        end
        if (in_i.last) begin
          if (full) begin
            num_o = 2'd2;
          end else begin
            num_o    = 2'd1;
            frame0_o = tail_f;
          end
          fill_d = '0;
          pkt_d  = '0;
          disc_d = 1'b0;
        end else begin
          fill_d = fill1;
          pkt_d  = pkt1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pkt_q  <= '0;
      disc_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      pkt_q  <= pkt_d;
      disc_q <= disc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i && !disc_q && in_i.has && !full) begin
      pending_q[fill_q] <= in_i.data;
    end
  end

endmodule

// ===== sv/can_command_segmenter.sv =====
`timescale 1ns / 1ps

// splits a command byte stream into classic can frames. one input word is taken every
// cycle unless output backpressure stalls it through the output registers; a frame appears
// on the output in the cycle after the word that completes it. a last word that both
// fills a frame and needs a separate check-byte frame yields two output words, and the
// input then holds off while the second frame sits in the spare output register

module can_command_segmenter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // target_address, command_code, data_byte
  input  logic        s_axis_tuser,  // has_data
  input  logic        s_axis_tlast,  // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // frame_id, data_len, byte_0 .. byte_7, zero pad
  output logic        m_axis_tuser,  // overflow
  output logic        m_axis_tlast   // final_frame
);
  import ccs_pkg::*;

  in_word_t   in_word;
  logic       in_fire, out_fire;
  logic [1:0] num;
  frame_t     frame0, frame1;
  frame_t     out_q, out_d, spare_q, spare_d;
  logic       out_valid_q, out_valid_d, spare_valid_q, spare_valid_d;

  assign in_word.addr = s_axis_tdata[7:0];
  assign in_word.code = s_axis_tdata[15:8];
  assign in_word.data = s_axis_tdata[23:16];
  assign in_word.has  = s_axis_tuser;
  assign in_word.last = s_axis_tlast;

  assign s_axis_tready = !spare_valid_q && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid_q && m_axis_tready;

  ccs_seg_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_fire_i(in_fire),
    .in_i     (in_word),
    .num_o    (num),
    .frame0_o (frame0),
    .frame1_o (frame1)
  );

  always_comb begin
    out_d         = out_q;
    out_valid_d   = out_valid_q;
    spare_d       = spare_q;
    spare_valid_d = spare_valid_q;
    if (spare_valid_q) begin
      if (out_fire) begin
        out_d         = spare_q;
        out_valid_d   = 1'b1;
        spare_valid_d = 1'b0;
      end
    end else if (in_fire) begin
      out_d         = frame0;
      out_valid_d   = (num != 2'd0);
      spare_d       = frame1;
      spare_valid_d = (num == 2'd2);
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      spare_valid_q <= 1'b0;
    end else begin
      out_valid_q   <= out_valid_d;
      spare_valid_q <= spare_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    spare_q <= spare_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.data, out_q.len, out_q.id};
  assign m_axis_tuser  = out_q.ovf;
  assign m_axis_tlast  = out_q.fin;

endmodule

// ===== sv/ccs_checker.sv =====
`timescale 1ns / 1ps

module ccs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // no new word while a frame is blocked at the output
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // frames before the final one are always full
  a_mid_frame_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[19:16] == 4'd8 && !m_axis_tuser)
    else $error("non-final frame not full");

  a_overflow_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[19:16] == 4'd8
      && m_axis_tdata[7:0] == 8'hFF)
    else $error("overflow frame malformed");

endmodule

bind can_command_segmenter ccs_checker u_ccs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
